// ----- src/pca_pkg.sv -----
package pca_pkg;

	localparam int unsigned MAX_POINTS_DEF = 256;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BELONGING_DISTANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BELONG_MODE        = 1'd1;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_TEST  = 2'd2;

	localparam logic [1:0] MODE_CENTROID = 2'd0;
	localparam logic [1:0] MODE_LAST     = 2'd1;
	localparam logic [1:0] MODE_ANY      = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic [15:0]        point_intensity;
	} in_word_t;

	typedef struct packed {
		logic               belongs;
		logic signed [15:0] centroid_x;
		logic signed [15:0] centroid_y;
		logic [15:0]        mean_intensity;
		logic [8:0]         point_count;
		logic               dropped;
	} out_word_t;

endpackage

// ----- src/pca_ram.sv -----
module pca_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/point_cluster_accumulator_core.sv -----
// Builds one 2-D point cluster and answers membership tests against it. A start
// word clears the cluster and stores its point, an add word appends a point (a
// full store drops it and flags dropped), and a test word checks its point against
// the centroid, the last stored point or every stored point, as belong_mode
// selects, with a strict squared-distance compare. Each input word yields one
// output word with the updated centroid, mean intensity and point count. One word
// is in flight at a time; in_ready is low while it is worked on. A start or an
// accepted add runs the bit-serial divider three times over SW-bit sums (SW = 16 +
// bits of the point count) to form the three means. The tests are paced by the
// single shared multiplier and the one read port of the point store; an any-point
// test reads the stored points one at a time until a hit or the last one. A
// dropped add or an unused kind goes straight to the output word. No clearing
// pass is needed after reset.
module point_cluster_accumulator_core #(
	parameter int unsigned MAX_POINTS = pca_pkg::MAX_POINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  pca_pkg::in_word_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pca_pkg::out_word_t             out_data,
	input  logic                           cfg_we,
	input  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pca_pkg::CFG_W-1:0]      cfg_data
);

	import pca_pkg::*;

	localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
	localparam int unsigned AW  = $clog2(MAX_POINTS);
	localparam int unsigned SW  = 16 + CW;
	localparam int unsigned MW  = (SW + 1 > 33) ? SW + 1 : 33;
	localparam int unsigned PW  = 2 * MW;
	localparam int unsigned BCW = $clog2(SW + 1);

	localparam logic [1:0] SEL_X = 2'd0;
	localparam logic [1:0] SEL_Y = 2'd1;
	localparam logic [1:0] SEL_I = 2'd2;

	typedef enum logic [19:0] {
		S_IDLE  = 20'h00001,
		S_LIM   = 20'h00002,
		S_LIMW  = 20'h00004,
		S_C_XN  = 20'h00008,
		S_C_DX  = 20'h00010,
		S_C_SQX = 20'h00020,
		S_C_YN  = 20'h00040,
		S_C_DY  = 20'h00080,
		S_C_SQY = 20'h00100,
		S_C_NN  = 20'h00200,
		S_C_LN  = 20'h00400,
		S_C_CMP = 20'h00800,
		S_P_RD  = 20'h01000,
		S_P_PD  = 20'h02000,
		S_P_SQX = 20'h04000,
		S_P_SQY = 20'h08000,
		S_P_CMP = 20'h10000,
		S_D_LD  = 20'h20000,
		S_D_RUN = 20'h40000,
		S_OUT   = 20'h80000
	} state_t;

	state_t                 state_q;
	logic [15:0]            dist_q;
	logic [1:0]             mode_q;
	logic signed [SW-1:0]   sum_x_q;
	logic signed [SW-1:0]   sum_y_q;
	logic [SW-1:0]          sum_i_q;
	logic [CW-1:0]          count_q;
	logic [15:0]            cx_q;
	logic [15:0]            cy_q;
	logic [15:0]            mi_q;
	logic                   hit_q;
	logic                   drop_q;
	logic [1:0]             sel_q;
	logic [BCW-1:0]         bit_q;
	logic                   out_valid_q;

	in_word_t               in_q;
	logic signed [PW-1:0]   prod_q;
	logic [PW-1:0]          acc_q;
	logic signed [MW-1:0]   dx_q;
	logic [31:0]            lim_q;
	logic [AW-1:0]          idx_q;
	logic [CW-1:0]          rem_q;
	logic [SW-1:0]          quo_q;
	logic                   neg_q;
	out_word_t              out_q;

	logic                   accept;
	logic                   full;
	logic [CW-1:0]          count_m1;
	logic                   mode_ok;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [31:0]            ram_wdata;
	logic [31:0]            ram_rdata;
	logic signed [SW-1:0]   pt_x_ext;
	logic signed [SW-1:0]   pt_y_ext;
	logic [SW-1:0]          pt_i_ext;

	logic signed [MW-1:0]   in_x_mw;
	logic signed [MW-1:0]   in_y_mw;
	logic signed [MW-1:0]   ent_x_mw;
	logic signed [MW-1:0]   ent_y_mw;
	logic signed [MW-1:0]   n_mw;
	logic signed [MW-1:0]   mul_a;
	logic signed [MW-1:0]   mul_b;
	logic signed [PW-1:0]   mul_p;
	logic                   mul_en;
	logic [PW-1:0]          sq_sum;
	logic                   pt_hit;

	logic [CW:0]            rem_sh;
	logic                   rem_ge;
	logic [CW:0]            rem_nx;
	logic [SW-1:0]          div_src;
	logic                   div_neg;
	logic [15:0]            quo16;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign full      = (count_q >= CW'(MAX_POINTS));
	assign count_m1  = count_q - CW'(1);
	assign mode_ok   = (mode_q == MODE_CENTROID) || (mode_q == MODE_LAST) ||
	                   (mode_q == MODE_ANY);

	assign ram_we    = accept && ((in_data.kind == KIND_START) ||
	                   ((in_data.kind == KIND_ADD) && !full));
	assign ram_waddr = (in_data.kind == KIND_START) ? '0 : count_q[AW-1:0];
	assign ram_wdata = {in_data.point_y, in_data.point_x};

	pca_ram #(
		.WIDTH (32),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign pt_x_ext = {{(SW-16){in_data.point_x[15]}}, in_data.point_x};
	assign pt_y_ext = {{(SW-16){in_data.point_y[15]}}, in_data.point_y};
	assign pt_i_ext = {{(SW-16){1'b0}}, in_data.point_intensity};

	assign in_x_mw  = {{(MW-16){in_q.point_x[15]}}, in_q.point_x};
	assign in_y_mw  = {{(MW-16){in_q.point_y[15]}}, in_q.point_y};
	assign ent_x_mw = {{(MW-16){ram_rdata[15]}}, ram_rdata[15:0]};
	assign ent_y_mw = {{(MW-16){ram_rdata[31]}}, ram_rdata[31:16]};
	assign n_mw     = {{(MW-CW){1'b0}}, count_q};

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (state_q)
			S_LIM: begin
				mul_a = {{(MW-16){1'b0}}, dist_q};
				mul_b = {{(MW-16){1'b0}}, dist_q};
			end
			S_C_XN: begin
				mul_a = in_x_mw;
				mul_b = n_mw;
			end
			S_C_YN: begin
				mul_a = in_y_mw;
				mul_b = n_mw;
			end
			S_C_SQX, S_C_SQY, S_P_SQX, S_P_SQY: begin
				mul_a = dx_q;
				mul_b = dx_q;
			end
			S_C_NN: begin
				mul_a = n_mw;
				mul_b = n_mw;
			end
			S_C_LN: begin
				mul_a = {{(MW-32){1'b0}}, lim_q};
				mul_b = prod_q[MW-1:0];
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign sq_sum = acc_q + $unsigned(prod_q);
	assign pt_hit = (sq_sum < PW'(lim_q));

	always_comb begin
		case (sel_q)
			SEL_X: begin
				div_neg = sum_x_q[SW-1];
				div_src = div_neg ? $unsigned(-sum_x_q) : $unsigned(sum_x_q);
			end
			SEL_Y: begin
				div_neg = sum_y_q[SW-1];
				div_src = div_neg ? $unsigned(-sum_y_q) : $unsigned(sum_y_q);
			end
			default: begin
				div_neg = 1'b0;
				div_src = sum_i_q;
			end
		endcase
	end

	assign rem_sh = {rem_q, quo_q[SW-1]};
	assign rem_ge = (rem_sh >= {1'b0, count_q});
	assign rem_nx = rem_ge ? (rem_sh - {1'b0, count_q}) : rem_sh;
	assign quo16  = neg_q ? (16'd0 - quo_q[15:0]) : quo_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dist_q      <= '0;
			mode_q      <= MODE_CENTROID;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_i_q     <= '0;
			count_q     <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			mi_q        <= '0;
			hit_q       <= 1'b0;
			drop_q      <= 1'b0;
			sel_q       <= SEL_X;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BELONGING_DISTANCE: dist_q <= cfg_data;
					REG_BELONG_MODE:        mode_q <= cfg_data[1:0];
					default: ;
				endcase
			end

			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q  <= 1'b0;
						drop_q <= 1'b0;
						sel_q  <= SEL_X;
						case (in_data.kind)
							KIND_START: begin
								sum_x_q <= pt_x_ext;
								sum_y_q <= pt_y_ext;
								sum_i_q <= pt_i_ext;
								count_q <= CW'(1);
								state_q <= S_D_LD;
							end
							KIND_ADD: begin
								if (full) begin
									drop_q  <= 1'b1;
									state_q <= S_OUT;
								end else begin
									sum_x_q <= sum_x_q + pt_x_ext;
									sum_y_q <= sum_y_q + pt_y_ext;
									sum_i_q <= sum_i_q + pt_i_ext;
									count_q <= count_q + CW'(1);
									state_q <= S_D_LD;
								end
							end
							KIND_TEST: begin
								if ((count_q == '0) || !mode_ok) begin
									state_q <= S_OUT;
								end else begin
									state_q <= S_LIM;
								end
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_LIM:   state_q <= S_LIMW;
				S_LIMW: begin
					if (mode_q == MODE_CENTROID) begin
						state_q <= S_C_XN;
					end else begin
						state_q <= S_P_RD;
					end
				end
				S_C_XN:  state_q <= S_C_DX;
				S_C_DX:  state_q <= S_C_SQX;
				S_C_SQX: state_q <= S_C_YN;
				S_C_YN:  state_q <= S_C_DY;
				S_C_DY:  state_q <= S_C_SQY;
				S_C_SQY: state_q <= S_C_NN;
				S_C_NN:  state_q <= S_C_LN;
				S_C_LN:  state_q <= S_C_CMP;
				S_C_CMP: begin
					hit_q   <= (acc_q < $unsigned(prod_q));
					state_q <= S_OUT;
				end
				S_P_RD:  state_q <= S_P_PD;
				S_P_PD:  state_q <= S_P_SQX;
				S_P_SQX: state_q <= S_P_SQY;
				S_P_SQY: state_q <= S_P_CMP;
				S_P_CMP: begin
					if (pt_hit) begin
						hit_q   <= 1'b1;
						state_q <= S_OUT;
					end else if ((mode_q == MODE_LAST) || (CW'(idx_q) == count_m1)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_P_RD;
					end
				end
				S_D_LD: begin
					bit_q   <= BCW'(SW);
					state_q <= S_D_RUN;
				end
				S_D_RUN: begin
					if (bit_q != '0) begin
						bit_q <= bit_q - BCW'(1);
					end else begin
						case (sel_q)
							SEL_X: begin
								cx_q    <= quo16;
								sel_q   <= SEL_Y;
								state_q <= S_D_LD;
							end
							SEL_Y: begin
								cy_q    <= quo16;
								sel_q   <= SEL_I;
								state_q <= S_D_LD;
							end
							default: begin
								mi_q    <= quo16;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
		end
		if (mul_en) begin
			prod_q <= mul_p;
		end
		case (state_q)
			S_LIMW: begin
				lim_q <= prod_q[31:0];
				idx_q <= (mode_q == MODE_LAST) ? count_m1[AW-1:0] : '0;
			end
			S_C_DX:  dx_q  <= prod_q[MW-1:0] - {{(MW-SW){sum_x_q[SW-1]}}, sum_x_q};
			S_C_YN:  acc_q <= $unsigned(prod_q);
			S_C_DY:  dx_q  <= prod_q[MW-1:0] - {{(MW-SW){sum_y_q[SW-1]}}, sum_y_q};
			S_C_NN:  acc_q <= sq_sum;
			S_P_PD:  dx_q  <= in_x_mw - ent_x_mw;
			S_P_SQX: dx_q  <= in_y_mw - ent_y_mw;
			S_P_SQY: acc_q <= $unsigned(prod_q);
			S_P_CMP: idx_q <= idx_q + AW'(1);
			S_D_LD: begin
				quo_q <= div_src;
				neg_q <= div_neg;
				rem_q <= '0;
			end
			S_D_RUN: begin
				if (bit_q != '0) begin
					rem_q <= rem_nx[CW-1:0];
					quo_q <= {quo_q[SW-2:0], rem_ge};
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.belongs        <= hit_q;
					out_q.centroid_x     <= cx_q;
					out_q.centroid_y     <= cy_q;
					out_q.mean_intensity <= mi_q;
					out_q.point_count    <= 9'(count_q);
					out_q.dropped        <= drop_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- src/pca_checker.sv -----
module pca_checker #(
	parameter int unsigned MAX_POINTS = pca_pkg::MAX_POINTS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input pca_pkg::out_word_t out_data
);

	import pca_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an input word was taken");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.dropped |-> out_data.point_count == 9'(MAX_POINTS))
		else $error("dropped flagged while store not full");

	a_drop_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.dropped && out_data.belongs))
		else $error("dropped and belongs both set");

endmodule

bind point_cluster_accumulator_core pca_checker #(
	.MAX_POINTS (MAX_POINTS)
) u_pca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
